[rtl/assert_macros.svh]
// Assertion macros used by the checker file tcs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/tcs_pkg.sv]
//------------------------------------------------------------------------------
// tcs_pkg
// Types and constants for the tracking candidate selector.
//------------------------------------------------------------------------------
`default_nettype none
package tcs_pkg;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned RUN_W   = 16;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned NPTS_W  = 7;
  localparam int unsigned RATIO_W = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 1'd1;
  localparam logic [RUN_W-1:0]   MAX_RUN_RST = 16'd3;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 9'd102;

  typedef enum logic [1:0] {
    CLS_A = 2'd0,
    CLS_B = 2'd1,
    CLS_C = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  typedef struct packed {
    logic [IDX_W-1:0]   point_index;
    logic               is_matched;
    logic               flow_tracked_status;
    logic [RUN_W-1:0]   status_run;
    logic [SCORE_W-1:0] point_score;
    logic [NPTS_W-1:0]  next_frame_points;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] candidate_index;
    logic             candidate_last;
    logic             list_empty;
  } out_word_t;

  // Word from front to back: classified record.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    cls_t               cls;
    logic [RUN_W-1:0]   run;
    logic [SCORE_W-1:0] score;
    logic [NPTS_W-1:0]  npts;
    logic               last;
  } rec_t;
endpackage
`default_nettype wire

[rtl/tcs_if.sv]
//------------------------------------------------------------------------------
// tcs_if
// Valid/ready channel carrying one word of type T.
//------------------------------------------------------------------------------
`default_nettype none
interface tcs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/tcs_front.sv]
//------------------------------------------------------------------------------
// tcs_front
// Classifies keypoint records and pushes them into a short queue.
//------------------------------------------------------------------------------
`default_nettype none
module tcs_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [tcs_pkg::RUN_W-1:0] max_run,
  tcs_if.sink                            in_ch,
  tcs_if.source                          q_ch
);
  import tcs_pkg::*;
  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW = 2;

  rec_t            mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  in_word_t        w;
  rec_t            rec;
  logic            push, pop;

  always_comb begin
    w = in_ch.data;
    rec.idx   = w.point_index;
    rec.run   = w.status_run;
    rec.score = w.point_score;
    rec.npts  = w.next_frame_points;
    rec.last  = w.last_point;
    if (w.is_matched) begin
      rec.cls = CLS_NONE;
    end else if (!w.flow_tracked_status) begin
      rec.cls = (w.status_run != '0) ? CLS_A : CLS_B;
    end else if (w.status_run < max_run) begin
      rec.cls = CLS_C;
    end else begin
      rec.cls = CLS_NONE;
    end
  end

  assign in_ch.ready = (cnt_r != (PW+1)'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_ch.valid = (cnt_r != '0);
  assign q_ch.data  = mem_r[rp_r];
  assign pop = q_ch.valid && q_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= rec;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/tcs_back.sv]
//------------------------------------------------------------------------------
// tcs_back
// Stores qualifying records, then selects, sorts if over the cap, and emits.
//------------------------------------------------------------------------------
`default_nettype none
module tcs_back #(
  parameter int unsigned POINT_CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tcs_pkg::RATIO_W-1:0] ratio,
  tcs_if.sink                              q_ch,
  tcs_if.source                            out_ch
);
  import tcs_pkg::*;
  localparam int unsigned AW = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(POINT_CAPACITY + 1);
  localparam int unsigned PROD_W = NPTS_W + RATIO_W;
  localparam int unsigned CAP_W = PROD_W - 8;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_CAP   = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_SCANW = 8'b00001000,
    S_SEL   = 8'b00010000,
    S_SELW  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_EMPTY = 8'b10000000
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    cls_t               cls;
    logic [RUN_W-1:0]   run;
    logic [SCORE_W-1:0] score;
  } ent_t;

  state_t           state_r, state_nxt;
  ent_t             mem_r [POINT_CAPACITY];
  ent_t             rd_r;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    cnt_r;
  logic [POINT_CAPACITY-1:0] used_r;
  logic [PROD_W-1:0] prod;
  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    lim;
  logic             over;
  logic [CW-1:0]    limit_r, emitted_r;
  logic             sort_r;
  cls_t             cur_cls_r;
  logic [CW-1:0]    scan_r;
  logic             have_r;
  logic [AW-1:0]    best_r;
  ent_t             best_e_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r, out_empty_r, out_v_r;
  logic             take, better, scan_done;
  logic [NPTS_W-1:0] npts_r;
  rec_t             q;
  out_word_t        ow;
  logic [AW-1:0]    scan_a;

  assign q = q_ch.data;
  assign q_ch.ready = (state_r == S_LOAD);
  assign take = q_ch.valid && q_ch.ready;
  assign scan_a = scan_r[AW-1:0];
  assign rd_addr = scan_a;
  assign scan_done = (scan_r == cnt_r);

  assign prod = PROD_W'(npts_r) * PROD_W'(ratio);
  assign cap  = prod[PROD_W-1:8];
  assign over = CAP_W'(cnt_r) > cap;
  assign lim  = over ? CW'(cap) : cnt_r;

  always_comb begin
    if (!have_r) begin
      better = 1'b1;
    end else if (!sort_r) begin
      better = 1'b0;
    end else begin
      case (cur_cls_r)
        CLS_A:   better = rd_r.run > best_e_r.run;
        CLS_B:   better = rd_r.score > best_e_r.score;
        default: better = rd_r.run < best_e_r.run;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (take && q.last) state_nxt = S_CAP;
      S_CAP:   state_nxt = (lim == '0) ? S_EMPTY : S_SCAN;
      S_SCAN:  state_nxt = scan_done ? S_SEL : S_SCANW;
      S_SCANW: state_nxt = S_SCAN;
      S_SEL:   state_nxt = have_r ? S_SELW : S_SCAN;
      S_SELW:  state_nxt = S_EMIT;
      S_EMIT:  if (!out_v_r) state_nxt = (emitted_r == limit_r) ? S_LOAD : S_SCAN;
      S_EMPTY: if (!out_v_r && emitted_r != '0) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem_r[rd_addr];
    if (take && q.cls != CLS_NONE && cnt_r < CW'(POINT_CAPACITY)) begin
      mem_r[cnt_r[AW-1:0]] <= '{idx: q.idx, cls: q.cls, run: q.run, score: q.score};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      used_r <= '0;
      out_v_r <= 1'b0;
      emitted_r <= '0;
      have_r <= 1'b0;
      scan_r <= '0;
      cur_cls_r <= CLS_A;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (take) begin
            npts_r <= q.npts;
            if (q.cls != CLS_NONE && cnt_r < CW'(POINT_CAPACITY)) cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CAP: begin
          limit_r <= lim;
          sort_r <= over;
          emitted_r <= '0;
          scan_r <= '0;
          have_r <= 1'b0;
          cur_cls_r <= CLS_A;
        end
        S_SCAN: begin
          if (scan_done) begin
            scan_r <= '0;
          end
        end
        S_SCANW: begin
          if (!used_r[scan_a] && rd_r.cls == cur_cls_r && better) begin
            have_r <= 1'b1;
            best_r <= scan_a;
            best_e_r <= rd_r;
          end
          scan_r <= scan_r + 1'b1;
        end
        S_SEL: begin
          if (!have_r) begin
            cur_cls_r <= cls_t'(cur_cls_r + 2'd1);
          end else begin
            used_r[best_r] <= 1'b1;
            out_idx_r <= best_e_r.idx;
            out_last_r <= (emitted_r + 1'b1 == limit_r);
            out_empty_r <= 1'b0;
            out_v_r <= 1'b1;
            emitted_r <= emitted_r + 1'b1;
            have_r <= 1'b0;
          end
        end
        S_SELW: ;
        S_EMIT: begin
          if (!out_v_r && emitted_r == limit_r) begin
            cnt_r <= '0;
            used_r <= '0;
          end
        end
        S_EMPTY: begin
          if (!out_v_r && emitted_r == '0) begin
            out_idx_r <= '0;
            out_last_r <= 1'b1;
            out_empty_r <= 1'b1;
            out_v_r <= 1'b1;
            emitted_r <= CW'(1);
          end else if (!out_v_r) begin
            cnt_r <= '0;
            used_r <= '0;
            emitted_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign ow = '{candidate_index: out_idx_r, candidate_last: out_last_r,
                list_empty: out_empty_r};
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = ow;
endmodule
`default_nettype wire

[rtl/tracking_candidate_selector.sv]
//------------------------------------------------------------------------------
// tracking_candidate_selector
// Top level: configuration registers, classifier front, selector back.
//------------------------------------------------------------------------------
// Records load at one per cycle while the front queue has room; the queue
// drains only while the back end is loading. After the last record, each
// emitted candidate takes one scan of the stored records (one read port), plus one scan per exhausted class.
`default_nettype none
module tracking_candidate_selector #(
  parameter int unsigned POINT_CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcs_pkg::CFG_W-1:0]   cfg_data,
  tcs_if.sink                              in_ch,
  tcs_if.source                            out_ch
);
  import tcs_pkg::*;
  logic [RUN_W-1:0]   max_run_r;
  logic [RATIO_W-1:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_run_r <= MAX_RUN_RST;
      ratio_r <= RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RUN: max_run_r <= cfg_data;
        REG_RATIO:   ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  tcs_if #(.T(rec_t)) q_ch ();

  tcs_front u_front (.clk, .rst_n, .max_run(max_run_r), .in_ch, .q_ch(q_ch.source));
  tcs_back #(.POINT_CAPACITY(POINT_CAPACITY)) u_back (
    .clk, .rst_n, .ratio(ratio_r), .q_ch(q_ch.sink), .out_ch);
endmodule
`default_nettype wire

[rtl/tcs_checker.sv]
//------------------------------------------------------------------------------
// tcs_checker
// Port-level checks for the tracking candidate selector.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tcs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire tcs_pkg::out_word_t out_data
);
  `CHK_IMPLY(a_empty_last, clk, rst_n, out_valid && out_data.list_empty, out_data.candidate_last, "empty not last")
  `CHK_IMPLY(a_empty_idx, clk, rst_n, out_valid && out_data.list_empty, out_data.candidate_index == '0, "empty index")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stall drop")
endmodule
bind tracking_candidate_selector tcs_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire

[test/tb_tracking_candidate_selector.sv]
//------------------------------------------------------------------------------
// tb_tracking_candidate_selector
// Streams keypoint frames into the selector under several register settings
// and random stalls on both channels. Predicts the candidate list of each
// frame and compares every result word against it.
//------------------------------------------------------------------------------
module tb_tracking_candidate_selector;
  import tcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES = 2 * CAPACITY + 40;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    cls_t               cls;
    logic [RUN_W-1:0]   run;
    logic [SCORE_W-1:0] score;
  } kept_point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tcs_if #(.T(in_word_t))  in_ch ();
  tcs_if #(.T(out_word_t)) out_ch ();

  tracking_candidate_selector #(.POINT_CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  in_word_t    point_q[$];
  out_word_t   candidate_q[$];
  kept_point_t kept_pts[CAPACITY];
  int unsigned kept_n = 0;
  logic [RUN_W-1:0]   run_limit;
  logic [RATIO_W-1:0] ratio;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors = 0;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit goes_ahead(kept_point_t a, kept_point_t b, cls_t c);
    if (c == CLS_A) return a.run > b.run;
    if (c == CLS_B) return a.score > b.score;
    return a.run < b.run;
  endfunction

  task automatic take_point(in_word_t w);
    cls_t c;
    int lst[3][$];
    int unsigned total;
    int unsigned cap;
    int unsigned lim;
    int unsigned sent;
    int k;
    int j;
    out_word_t r;
    c = CLS_NONE;
    if (!w.is_matched) begin
      if (!w.flow_tracked_status) c = (w.status_run > 0) ? CLS_A : CLS_B;
      else if (w.status_run < run_limit) c = CLS_C;
    end
    if (c != CLS_NONE && kept_n < CAPACITY) begin
      kept_pts[kept_n] = '{w.point_index, c, w.status_run, w.point_score};
      kept_n++;
    end
    if (!w.last_point) return;
    for (int i = 0; i < kept_n; i++) lst[kept_pts[i].cls] = {lst[kept_pts[i].cls], i};
    total = kept_n;
    cap = (int'(w.next_frame_points) * int'(ratio)) >> 8;
    if (total > cap) begin
      for (int cc = 0; cc < 3; cc++) begin
        for (int i = 1; i < lst[cc].size(); i++) begin
          k = lst[cc][i];
          j = i;
          while (j > 0 && goes_ahead(kept_pts[k], kept_pts[lst[cc][j-1]], cls_t'(cc))) begin
            lst[cc][j] = lst[cc][j-1];
            j--;
          end
          lst[cc][j] = k;
        end
      end
    end
    lim = (total < cap) ? total : cap;
    sent = 0;
    for (int cc = 0; cc < 3; cc++) begin
      for (int i = 0; i < lst[cc].size(); i++) begin
        if (sent < lim) begin
          r.candidate_index = kept_pts[lst[cc][i]].idx;
          r.candidate_last = (sent + 1 == lim);
          r.list_empty = 1'b0;
          candidate_q = {candidate_q, r};
          sent++;
        end
      end
    end
    if (sent == 0) begin
      r.candidate_index = '0;
      r.candidate_last = 1'b1;
      r.list_empty = 1'b1;
      candidate_q = {candidate_q, r};
    end
    kept_n = 0;
  endtask

  // driver: advance to the next word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_ch.valid || in_ch.ready) begin
        if (point_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= point_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) take_point(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (candidate_q.size() == 0) begin
          $error("unexpected result word %p", out_ch.data);
          errors++;
        end else begin
          exp_w = candidate_q.pop_front();
          if (out_ch.data.candidate_index !== exp_w.candidate_index) begin
            $error("candidate_index expected %0d got %0d",
                   exp_w.candidate_index, out_ch.data.candidate_index);
            errors++;
          end
          if (out_ch.data.candidate_last !== exp_w.candidate_last) begin
            $error("candidate_last expected %0d got %0d",
                   exp_w.candidate_last, out_ch.data.candidate_last);
            errors++;
          end
          if (out_ch.data.list_empty !== exp_w.list_empty) begin
            $error("list_empty expected %0d got %0d",
                   exp_w.list_empty, out_ch.data.list_empty);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (point_q.size() == 0 && !in_ch.valid && candidate_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic in_word_t make_point(logic [IDX_W-1:0] idx, bit matched, bit flow,
                                          logic [RUN_W-1:0] run, logic [SCORE_W-1:0] score,
                                          logic [NPTS_W-1:0] npts, bit last);
    in_word_t w;
    w.point_index = idx;
    w.is_matched = matched;
    w.flow_tracked_status = flow;
    w.status_run = run;
    w.point_score = score;
    w.next_frame_points = npts;
    w.last_point = last;
    return w;
  endfunction

  task automatic add_point(in_word_t w);
    point_q = {point_q, w};
  endtask

  task automatic add_frame(int unsigned n);
    bit ties;
    logic [RUN_W-1:0] run;
    logic [NPTS_W-1:0] npts;
    ties = $urandom_range(0, 1);
    npts = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(0, 64));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0: run = '0;
        1: run = 16'd1;
        2: run = run_limit - 16'd1;
        3: run = run_limit;
        4: run = 16'hFFFF;
        5: run = 16'($urandom_range(0, 4));
        default: run = 16'($urandom);
      endcase
      add_point(make_point(6'($urandom_range(0, 63)), $urandom_range(0, 4) == 0,
                           $urandom_range(0, 1), run,
                           ties ? 32'($urandom_range(0, 3)) : 32'($urandom),
                           npts, i == n - 1));
    end
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_ch.valid || candidate_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [RUN_W-1:0] lim_v, logic [RATIO_W-1:0] ratio_v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_RUN;
    cfg_data <= lim_v;
    @(posedge clk);
    cfg_index <= REG_RATIO;
    cfg_data <= CFG_W'(ratio_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    run_limit = lim_v;
    ratio = ratio_v;
  endtask

  initial begin
    logic [RUN_W-1:0]   lim_set[8]   = '{16'd3, 16'd1, 16'hFFFF, 16'd0, 16'd2, 16'hFFFF,
                                         16'd1, 16'd100};
    logic [RATIO_W-1:0] ratio_set[8] = '{9'd102, 9'd256, 9'd511, 9'd0, 9'd128, 9'd256,
                                         9'd511, 9'd64};
    int unsigned budget;
    int unsigned n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    run_limit = MAX_RUN_RST;
    ratio = RATIO_RST;
    send_idle_pct = 25;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_point(make_point(6'd5, 1, 0, 16'd7, 32'd1, 7'd64, 1));
    add_point(make_point(6'd1, 0, 0, 16'd5, 32'd0, 7'd0, 0));
    add_point(make_point(6'd2, 0, 0, 16'd9, 32'd0, 7'd0, 0));
    add_point(make_point(6'd3, 0, 0, 16'd0, 32'd10, 7'd0, 0));
    add_point(make_point(6'd3, 0, 0, 16'd0, 32'hFFFF_FFFF, 7'd0, 0));
    add_point(make_point(6'd63, 0, 1, 16'd2, 32'd0, 7'd0, 0));
    add_point(make_point(6'd0, 0, 1, 16'd0, 32'd0, 7'd0, 0));
    add_point(make_point(6'd9, 0, 1, 16'd3, 32'd0, 7'd0, 0));
    add_point(make_point(6'd8, 0, 0, 16'hFFFF, 32'd0, 7'd10, 1));
    add_point(make_point(6'd1, 0, 0, 16'd5, 32'd0, 7'd0, 0));
    add_point(make_point(6'd2, 0, 0, 16'd9, 32'd0, 7'd0, 0));
    add_point(make_point(6'd3, 0, 0, 16'd0, 32'd7, 7'd0, 0));
    add_point(make_point(6'd4, 0, 0, 16'd0, 32'd7, 7'd0, 0));
    add_point(make_point(6'd63, 0, 1, 16'd1, 32'd0, 7'd127, 1));
    add_point(make_point(6'd42, 0, 0, 16'd0, 32'd3, 7'd0, 1));
    add_point(make_point(6'd42, 1, 1, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F, 1));
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 25;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) write_regs(lim_set[p], ratio_set[p]);
      budget = 0;
      while (budget < 26) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
        add_frame(n);
        budget += n;
      end
      drain();
    end

    if (errors == 0 && candidate_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[tracking_candidate_selector.f]
+incdir+rtl
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/tcs_front.sv
rtl/tcs_back.sv
rtl/tracking_candidate_selector.sv
rtl/tcs_checker.sv
test/tb_tracking_candidate_selector.sv
